>>> rtl/mbl_pkg.sv
// ----------------------------------------------------------------------------
// mbl_pkg
// Shared types, constants and helper functions of the memory budget ledger.
// ----------------------------------------------------------------------------
`default_nettype none

package mbl_pkg;

  // default number of subsystem entries
  localparam int SUBSYSTEMS_DFLT = 8;

  // cap classes: one half, one tenth, one twentieth of the budget
  localparam logic [1:0] CLS_HALF      = 2'd0;
  localparam logic [1:0] CLS_TENTH     = 2'd1;
  localparam logic [1:0] CLS_TWENTIETH = 2'd2;
  localparam int         N_CLS         = 3;

  localparam logic [5:0] PCT_HALF      = 6'd50;
  localparam logic [5:0] PCT_TENTH     = 6'd10;
  localparam logic [5:0] PCT_TWENTIETH = 6'd5;

  // percent limit for the backpressure threshold, and the divisor
  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [7:0] DIVISOR  = 8'd100;

  // floor(x / 100) for x below 12800 as a multiply and shift
  localparam logic [13:0] RECIP_100 = 14'd5243;
  localparam int          RECIP_SH  = 19;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_GAUGE,
    OP_QUERY
  } op_t;

  typedef enum logic {
    LG_IDLE,
    LG_EXEC
  } lg_state_t;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_DIVB,
    CP_CAP,
    CP_DIVC
  } cp_state_t;

  // one ledger entry
  typedef struct packed {
    logic [63:0] peak;
    logic [63:0] count;
  } entry_t;

  // budget and derived caps, handed from the cap unit to the ledger
  typedef struct packed {
    logic                   busy;
    logic [63:0]            budget;
    logic [N_CLS-1:0][63:0] cap;
    logic [N_CLS-1:0][63:0] capq;
    logic [N_CLS-1:0][6:0]  capr;
  } cap_info_t;

  // cap class of a subsystem
  function automatic logic [1:0] cap_class(input logic [2:0] sub);
    logic [1:0] cls;
    case (sub) inside
      3'd0:         cls = CLS_HALF;
      [3'd1:3'd3]:  cls = CLS_TENTH;
      default:      cls = CLS_TWENTIETH;
    endcase
    return cls;
  endfunction

  function automatic logic [5:0] class_pct(input logic [1:0] cls);
    logic [5:0] pct;
    case (cls)
      CLS_HALF:  pct = PCT_HALF;
      CLS_TENTH: pct = PCT_TENTH;
      default:   pct = PCT_TWENTIETH;
    endcase
    return pct;
  endfunction

  // small quotient by 100, exact for x below 12800
  function automatic logic [6:0] div100_small(input logic [13:0] x);
    logic [27:0] prod;
    prod = {14'd0, x} * {14'd0, RECIP_100};
    return 7'(prod >> RECIP_SH);
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] clamp_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[64] ? '0 : d[63:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/mbl_div100.sv
// ----------------------------------------------------------------------------
// mbl_div100
// Divider by 100 working on one byte of the dividend per cycle: eight steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mbl_div100
  import mbl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] operand,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [6:0]       remainder
);

  logic        busy_r;
  logic        done_r;
  logic [2:0]  cnt_r;
  logic [63:0] quo_r;
  logic [6:0]  rem_r;

  logic [14:0] part;
  logic [27:0] prod;
  logic [7:0]  q_dig;
  logic [6:0]  rem_dig;

  // one byte step: (rem * 256 + next byte) / 100 by reciprocal multiply,
  // exact as the partial dividend stays below 25600
  always_comb begin
    part    = {rem_r, quo_r[63:56]};
    prod    = {13'd0, part} * {14'd0, RECIP_100};
    q_dig   = 8'(prod >> RECIP_SH);
    rem_dig = 7'(part - ({7'd0, q_dig} * {7'd0, DIVISOR}));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend bytes shift out, quotient bytes shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= operand;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[55:0], q_dig};
      rem_r <= rem_dig;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> rtl/mbl_cap_unit.sv
// ----------------------------------------------------------------------------
// mbl_cap_unit
// Holds the budget and works out the per-class caps and their quotient and
// remainder by 100 after each budget write, using one serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mbl_cap_unit
  import mbl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [63:0] wr_budget,
  output cap_info_t        info
);

  cp_state_t              st_r, st_nxt;
  logic [1:0]             k_r, k_nxt;
  logic [63:0]            budget_r;
  logic [63:0]            bq_r;
  logic [6:0]             br_r;
  logic [N_CLS-1:0][63:0] cap_r;
  logic [N_CLS-1:0][63:0] capq_r;
  logic [N_CLS-1:0][6:0]  capr_r;

  logic        div_start;
  logic [63:0] div_operand;
  logic        div_done;
  logic [63:0] div_quo;
  logic [6:0]  div_rem;
  logic [63:0] cap_val;
  logic [5:0]  pct;

  mbl_div100 u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .operand   (div_operand),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // cap of the current class: q*p + (r*p)/100
  always_comb begin
    pct     = class_pct(k_r);
    cap_val = 64'(bq_r * {58'd0, pct})
            + {57'd0, div100_small({7'd0, br_r} * {8'd0, pct})};
  end

  // sequencer
  always_comb begin
    st_nxt      = st_r;
    k_nxt       = k_r;
    div_start   = 1'b0;
    div_operand = wr_budget;
    case (st_r)
      CP_IDLE: begin
        if (wr_en) begin
          div_start = 1'b1;
          st_nxt    = CP_DIVB;
        end
      end
      CP_DIVB: begin
        if (div_done) begin
          k_nxt  = CLS_HALF;
          st_nxt = CP_CAP;
        end
      end
      CP_CAP: begin
        div_start   = 1'b1;
        div_operand = cap_val;
        st_nxt      = CP_DIVC;
      end
      CP_DIVC: begin
        if (div_done) begin
          if (k_r == CLS_TWENTIETH) begin
            st_nxt = CP_IDLE;
          end else begin
            k_nxt  = k_r + 2'd1;
            st_nxt = CP_CAP;
          end
        end
      end
      default: st_nxt = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CP_IDLE;
      k_r  <= CLS_HALF;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
    end
  end

  // budget and derived values, all zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
      bq_r     <= '0;
      br_r     <= '0;
      cap_r    <= '0;
      capq_r   <= '0;
      capr_r   <= '0;
    end else begin
      if (st_r == CP_IDLE && wr_en) begin
        budget_r <= wr_budget;
      end
      if (st_r == CP_DIVB && div_done) begin
        bq_r <= div_quo;
        br_r <= div_rem;
      end
      if (st_r == CP_CAP) begin
        cap_r[k_r] <= cap_val;
      end
      if (st_r == CP_DIVC && div_done) begin
        capq_r[k_r] <= div_quo;
        capr_r[k_r] <= div_rem;
      end
    end
  end

  assign info.busy   = (st_r != CP_IDLE);
  assign info.budget = budget_r;
  assign info.cap    = cap_r;
  assign info.capq   = capq_r;
  assign info.capr   = capr_r;

endmodule

`default_nettype wire

>>> rtl/mbl_store.sv
// ----------------------------------------------------------------------------
// mbl_store
// Subsystem count and peak memory: one write and one registered read port,
// with a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mbl_store
  import mbl_pkg::*;
#(
  parameter int DEPTH = SUBSYSTEMS_DFLT,
  parameter int IDX_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output entry_t                rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire entry_t           wr_data
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rd_q_r;
  logic             rd_vld_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

>>> rtl/memory_budget_ledger.sv
// ----------------------------------------------------------------------------
// memory_budget_ledger
// Byte accounting for a set of subsystems and their total, with peaks,
// remaining budget and cap and backpressure flags.
// ----------------------------------------------------------------------------
//  channel  | handshake              | word
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_stall    | opcode, subsystem, amount, bp_thresh
//  out      | out_valid / out_stall  | counts, peaks, remaining, three flags
//  cfg      | cfg_valid / cfg_ready  | budget
//
//  An item goes through a read of the subsystem entry from the ledger
//  memory, then the update, write-back and result register load.
//  A budget write starts the cap unit, which stays busy through four
//  divisions by 100 at one byte a cycle; items are held off meanwhile.
//  A stalled result holds the update cycle; a new item is taken while an
//  earlier result waits in the output register.
//  Synchronous active-low reset clears totals, budget and entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_budget_ledger
  import mbl_pkg::*;
#(
  parameter int SUBSYSTEMS = SUBSYSTEMS_DFLT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [2:0]  in_subsystem,
  input  wire logic [63:0] in_amount,
  input  wire logic [6:0]  in_bp_thresh,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_subsystem_bytes,
  output logic [63:0]      out_subsystem_peak,
  output logic [63:0]      out_total_bytes,
  output logic [63:0]      out_total_peak,
  output logic [63:0]      out_bytes_remaining,
  output logic             out_over_budget,
  output logic             out_subsystem_over_cap,
  output logic             out_backpressure,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_budget
);

  localparam int         IDX_W     = (SUBSYSTEMS > 1) ? $clog2(SUBSYSTEMS) : 1;
  localparam logic [4:0] SUB_LIMIT = 5'(SUBSYSTEMS);

  lg_state_t   state_r, state_nxt;
  cap_info_t   cap_info;
  entry_t      rd_ent;
  entry_t      wr_ent;

  logic [3:0]       sub_ext;
  logic             sub_ok;
  logic [1:0]       cls_in;
  logic [IDX_W-1:0] rd_idx;
  logic             in_acc;
  logic             exec_fire;
  logic             wr_en;
  logic [63:0]      bp_lim_nxt;

  // item registers
  op_t              op_r;
  logic [IDX_W-1:0] idx_r;
  logic             ok_r;
  logic [63:0]      amt_r;
  logic             thr_ok_r;
  logic [1:0]       cls_r;
  logic [63:0]      bp_lim_r;

  // ledger totals
  logic [63:0] total_r;
  logic [63:0] tpk_r;

  // update results
  logic [63:0] cnt_new, pk_new, tot_new, tpk_new, rem_new;
  logic [63:0] cap_sel;
  logic        ovb_new, ovc_new, bp_new;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] o_sb_r, o_sp_r, o_tb_r, o_tp_r, o_rem_r;
  logic        o_ovb_r, o_ovc_r, o_bp_r;

  mbl_cap_unit u_cap (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_budget (cfg_budget),
    .info      (cap_info)
  );

  mbl_store #(
    .DEPTH (SUBSYSTEMS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && sub_ok),
    .rd_idx  (rd_idx),
    .rd_data (rd_ent),
    .wr_en   (wr_en),
    .wr_idx  (idx_r),
    .wr_data (wr_ent)
  );

  // input decode
  assign sub_ext   = {1'b0, in_subsystem};
  assign sub_ok    = ({2'b00, in_subsystem} < SUB_LIMIT);
  assign rd_idx    = sub_ext[IDX_W-1:0];
  assign cls_in    = cap_class(in_subsystem);
  assign in_stall  = (state_r != LG_IDLE) || cap_info.busy || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = !cap_info.busy;

  // backpressure limit: floor(cap * thr / 100) in quotient and remainder form
  assign bp_lim_nxt = 64'(cap_info.capq[cls_in] * {57'd0, in_bp_thresh})
                    + {57'd0, div100_small({7'd0, cap_info.capr[cls_in]}
                                           * {7'd0, in_bp_thresh})};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= op_t'(in_opcode);
      idx_r    <= rd_idx;
      ok_r     <= sub_ok;
      amt_r    <= in_amount;
      thr_ok_r <= (in_bp_thresh <= PCT_FULL);
      cls_r    <= cls_in;
      bp_lim_r <= bp_lim_nxt;
    end
  end

  // entry and total update
  always_comb begin
    cnt_new = rd_ent.count;
    tot_new = total_r;
    if (ok_r) begin
      case (op_r)
        OP_ALLOC: begin
          cnt_new = sat_add(rd_ent.count, amt_r);
          tot_new = sat_add(total_r, amt_r);
        end
        OP_FREE: begin
          cnt_new = clamp_sub(rd_ent.count, amt_r);
          tot_new = clamp_sub(total_r, amt_r);
        end
        OP_GAUGE: begin
          cnt_new = amt_r;
          if (amt_r > rd_ent.count) begin
            tot_new = sat_add(total_r, amt_r - rd_ent.count);
          end else begin
            tot_new = clamp_sub(total_r, rd_ent.count - amt_r);
          end
        end
        default: begin
          cnt_new = rd_ent.count;
        end
      endcase
    end
    pk_new  = (cnt_new > rd_ent.peak) ? cnt_new : rd_ent.peak;
    tpk_new = (tot_new > tpk_r) ? tot_new : tpk_r;
    wr_ent.count = cnt_new;
    wr_ent.peak  = pk_new;
  end

  // budget and flags
  always_comb begin
    cap_sel = cap_info.cap[cls_r];
    if (cap_info.budget == '0) begin
      rem_new = '1;
    end else if (tot_new >= cap_info.budget) begin
      rem_new = '0;
    end else begin
      rem_new = cap_info.budget - tot_new;
    end
    ovb_new = (cap_info.budget != '0) && (tot_new > cap_info.budget);
    ovc_new = ok_r && (cap_info.budget != '0) && (cnt_new > cap_sel);
    bp_new  = ok_r && (cap_info.budget != '0) && (cap_sel != '0) && thr_ok_r
              && (cnt_new >= bp_lim_r);
  end

  // control
  always_comb begin
    state_nxt     = state_r;
    exec_fire     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      LG_IDLE: begin
        if (in_acc) begin
          state_nxt = LG_EXEC;
        end
      end
      LG_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          exec_fire     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = LG_IDLE;
        end
      end
      default: state_nxt = LG_IDLE;
    endcase
    wr_en = exec_fire && ok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LG_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      tpk_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        total_r <= tot_new;
        tpk_r   <= tpk_new;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      o_sb_r  <= ok_r ? cnt_new : '0;
      o_sp_r  <= ok_r ? pk_new : '0;
      o_tb_r  <= tot_new;
      o_tp_r  <= tpk_new;
      o_rem_r <= rem_new;
      o_ovb_r <= ovb_new;
      o_ovc_r <= ovc_new;
      o_bp_r  <= bp_new;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_subsystem_bytes    = o_sb_r;
  assign out_subsystem_peak     = o_sp_r;
  assign out_total_bytes        = o_tb_r;
  assign out_total_peak         = o_tp_r;
  assign out_bytes_remaining    = o_rem_r;
  assign out_over_budget        = o_ovb_r;
  assign out_subsystem_over_cap = o_ovc_r;
  assign out_backpressure       = o_bp_r;

  // checks
  a_no_item_while_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !cap_info.busy)
    else $error("item taken while caps are being worked out");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == LG_EXEC && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("update cycle left no result");

  a_total_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_tp_r >= o_tb_r))
    else $error("total peak below total");

  a_sub_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_sp_r >= o_sb_r))
    else $error("subsystem peak below count");

  a_over_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_ovb_r) |-> (o_rem_r == '0))
    else $error("over budget with bytes remaining");

endmodule

`default_nettype wire
